FILE: rtl/tmq_pkg.sv
// Package for the timer expiry queue: field widths, codes and word types.
// No dependencies; imported by tmq_scan_unit and timer_expiry_queue.
`default_nettype none

package tmq_pkg;

  localparam int TIME_W    = 32;
  localparam int ORDER_W   = 32;
  localparam int SLOT_ID_W = 4;

  // Command codes
  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_CANCEL  = 2'd1;
  localparam logic [1:0] ACT_PROCESS = 2'd2;

  // Event kinds
  localparam logic [1:0] EVT_ADDED     = 2'd0;
  localparam logic [1:0] EVT_EXPIRED   = 2'd1;
  localparam logic [1:0] EVT_CANCELLED = 2'd2;
  localparam logic [1:0] EVT_NONE      = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_NOT_PENDING = 2'd2;

  typedef struct packed {
    logic [1:0]           action;
    logic [SLOT_ID_W-1:0] timer_slot;
    logic [TIME_W-1:0]    expire_at;
    logic [TIME_W-1:0]    repeat_interval;
    logic [TIME_W-1:0]    current_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           event_kind;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [1:0]           status;
    logic                 wakeup;
    logic                 next_valid;
    logic [TIME_W-1:0]    next_time;
    logic                 last;
  } evt_t;

  // One timer slot as held in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0]  expire;
    logic [TIME_W-1:0]  period;
    logic [ORDER_W-1:0] order;
  } slot_entry_t;

  // Control from the sequencer to the scan unit
  typedef struct packed {
    logic step;   // an entry is presented this cycle
    logic start;  // presented entry is the first of a pass
    logic pick;   // expiry pick pass instead of an earliest/free pass
  } scan_ctl_t;

  // Status of the scan unit after a pass
  typedef struct packed {
    logic found;       // a candidate was seen
    logic free_found;  // an unused slot was seen
  } scan_flags_t;

endpackage

`default_nettype wire

FILE: rtl/tmq_scan_unit.sv
// Shared compare unit of the timer expiry queue: folds one slot per cycle,
// in cycles with ctl.step set, into a running best (earliest, or earliest
// expired by time then order). Depends on tmq_pkg.
`default_nettype none

module tmq_scan_unit
  import tmq_pkg::*;
#(
  parameter int SLOT_W = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire scan_ctl_t           ctl,
  input  wire logic [SLOT_W-1:0]   slot_idx,
  input  wire logic                slot_used,
  input  wire logic                slot_taken,
  input  wire logic [TIME_W-1:0]   entry_expire,
  input  wire logic [ORDER_W-1:0]  entry_order,
  input  wire logic [TIME_W-1:0]   now,
  output scan_flags_t              flags,
  output logic [TIME_W-1:0]        best_expire,
  output logic [SLOT_W-1:0]        best_idx,
  output logic [SLOT_W-1:0]        free_idx
);

  logic [ORDER_W-1:0] best_order;
  logic               base_found;
  logic               base_free;
  logic               cand;
  logic               less;

  always_comb begin
    base_found = ctl.start ? 1'b0 : flags.found;
    base_free  = ctl.start ? 1'b0 : flags.free_found;
    cand       = slot_used && (!ctl.pick || (!slot_taken && entry_expire <= now));
    less       = !base_found || (entry_expire < best_expire) ||
                 (ctl.pick && entry_expire == best_expire && entry_order < best_order);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (ctl.step) begin
      flags.found <= base_found | cand;
      if (cand && less) begin
        best_expire <= entry_expire;
        best_order  <= entry_order;
        best_idx    <= slot_idx;
      end
      // Keep the lowest unused slot
      if (!slot_used && !base_free) begin
        flags.free_found <= 1'b1;
        free_idx         <= slot_idx;
      end else begin
        flags.free_found <= base_free;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/timer_expiry_queue.sv
// Timer expiry queue top level: sequencer, slot memory, expiry list and
// result register. Depends on tmq_pkg and tmq_scan_unit.
`default_nettype none

// The queue holds NUM_TIMERS timer slots ordered by expiration time, ties
// going to the slot inserted first. Each cmd word is one command: add
// (takes the lowest free slot and reports it, with wakeup set when it is the
// new earliest timer), cancel, or process (reports every timer due at
// current_time, earliest first, then rearms periodic timers at
// current_time + interval, saturating, and frees the one-shot ones). Every
// evt word carries the earliest pending expiration after the whole command.
// The block handles one command at a time; cmd_stall is high from the cycle
// after acceptance until its last evt word has been loaded into the output
// register, so a new command may be taken while that word still waits.
// Slot data lives in a single-port-read memory, and one shared compare unit
// walks it one slot per cycle; the consumer can hold evt_stall to delay the
// result words. Slot valid bits clear at reset; slot contents are only used
// after they have been written, so the memory needs no clearing pass.
module timer_expiry_queue
  import tmq_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      evt_valid,
  input  wire logic evt_stall,
  output evt_t      evt
);

  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int WIDE_W = SLOT_W + SLOT_ID_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,   // find free slot and current earliest
    S_A_DEC,    // store the new timer
    S_P_SCAN,   // pick next due timer
    S_P_NEXT,   // record the pick or move on
    S_R_LA,     // rearm: fetch slot id from the list
    S_R_LB,     // rearm: fetch slot entry
    S_R_W,      // rearm: write back or free
    S_F_SCAN,   // final earliest scan
    S_F_DONE,   // single result or start of expiry list
    S_E_RD,     // emit: fetch slot id
    S_E_LD      // emit: load result word
  } state_t;

  state_t state;

  // Command in flight and single-result fields
  cmd_t                 item;
  logic [1:0]           res_kind;
  logic [1:0]           res_status;
  logic [SLOT_ID_W-1:0] res_slot;
  logic                 res_wake;

  logic [ORDER_W-1:0]    order_counter;
  logic [NUM_TIMERS-1:0] slot_valid;
  logic [NUM_TIMERS-1:0] taken;

  // Scan walk: issue counter and the registered-read pipeline behind it
  logic [CNT_W-1:0]  cnt;
  logic              pv;
  logic [SLOT_W-1:0] pidx;
  // Expiry list fill count and read index
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  k;

  // Slot memory and expiry list memory
  slot_entry_t       slot_mem [NUM_TIMERS];
  slot_entry_t       mem_q;
  logic [SLOT_W-1:0] list_mem [NUM_TIMERS];
  logic [SLOT_W-1:0] list_q;

  logic              scan_st;
  logic              issue;
  logic              scan_last;
  logic              out_free;
  logic              evt_load;
  logic [SLOT_W-1:0] mem_raddr;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_entry_t       mem_wdata;
  logic              list_we;
  logic [TIME_W:0]   rearm_sum;
  logic [TIME_W-1:0] rearm_time;
  logic [WIDE_W-1:0] free_wide;
  logic [WIDE_W-1:0] list_wide;
  logic [WIDE_W-1:0] tslot_wide;
  logic              tslot_hit;
  logic [TIME_W-1:0] next_time;
  logic              k_last;

  scan_ctl_t         ctl;
  scan_flags_t       flags;
  logic [TIME_W-1:0] best_expire;
  logic [SLOT_W-1:0] best_idx;
  logic [SLOT_W-1:0] free_idx;

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    scan_st   = (state == S_A_SCAN) || (state == S_P_SCAN) || (state == S_F_SCAN);
    issue     = scan_st && (cnt < CNT_W'(NUM_TIMERS));
    scan_last = pv && (pidx == SLOT_W'(NUM_TIMERS - 1));
    out_free  = !evt_valid || !evt_stall;
    k_last    = ((k + CNT_W'(1)) == n);
    // A result word is loaded this cycle
    evt_load  = out_free &&
                (((state == S_F_DONE) && !((item.action == ACT_PROCESS) && (n != '0))) ||
                 (state == S_E_LD));

    ctl.step  = pv;
    ctl.start = (pidx == '0);
    ctl.pick  = (state == S_P_SCAN);

    // Read the listed slot while rearming, else follow the scan walk
    mem_raddr = (state == S_R_LB) ? list_q : cnt[SLOT_W-1:0];

    rearm_sum  = {1'b0, item.current_time} + {1'b0, mem_q.period};
    rearm_time = rearm_sum[TIME_W] ? '1 : rearm_sum[TIME_W-1:0];

    mem_we    = ((state == S_A_DEC) && flags.free_found) ||
                ((state == S_R_W) && (mem_q.period != '0));
    mem_waddr = (state == S_A_DEC) ? free_idx : list_q;
    if (state == S_A_DEC) begin
      mem_wdata = '{expire: item.expire_at, period: item.repeat_interval,
                    order: order_counter};
    end else begin
      mem_wdata = '{expire: rearm_time, period: mem_q.period, order: order_counter};
    end

    list_we = (state == S_P_NEXT) && flags.found;

    free_wide  = WIDE_W'(free_idx);
    list_wide  = WIDE_W'(list_q);
    tslot_wide = WIDE_W'(cmd.timer_slot);
    tslot_hit  = (tslot_wide < WIDE_W'(NUM_TIMERS)) &&
                 slot_valid[tslot_wide[SLOT_W-1:0]];

    next_time = flags.found ? best_expire : '1;
  end

  // Slot memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= slot_mem[mem_raddr];
  end

  // Expiry list: picks in emission order
  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[n[SLOT_W-1:0]] <= best_idx;
    end
    list_q <= list_mem[k[SLOT_W-1:0]];
  end

  tmq_scan_unit #(
    .SLOT_W (SLOT_W)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .slot_idx     (pidx),
    .slot_used    (slot_valid[pidx]),
    .slot_taken   (taken[pidx]),
    .entry_expire (mem_q.expire),
    .entry_order  (mem_q.order),
    .now          (item.current_time),
    .flags        (flags),
    .best_expire  (best_expire),
    .best_idx     (best_idx),
    .free_idx     (free_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      evt_valid     <= 1'b0;
      slot_valid    <= '0;
      taken         <= '0;
      order_counter <= '0;
      cnt           <= '0;
      pv            <= 1'b0;
      pidx          <= '0;
      n             <= '0;
      k             <= '0;
    end else begin
      // Advance the scan walk; the read data lands in the following cycle
      pv   <= issue;
      pidx <= cnt[SLOT_W-1:0];
      if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end

      // Drop the result word once taken, unless a new one replaces it
      if (evt_valid && !evt_stall && !evt_load) begin
        evt_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item     <= cmd;
            n        <= '0;
            k        <= '0;
            cnt      <= '0;
            taken    <= '0;
            res_wake <= 1'b0;
            case (cmd.action)
              ACT_ADD: begin
                state <= S_A_SCAN;
              end
              ACT_CANCEL: begin
                res_kind <= EVT_CANCELLED;
                res_slot <= cmd.timer_slot;
                if (tslot_hit) begin
                  slot_valid[tslot_wide[SLOT_W-1:0]] <= 1'b0;
                  res_status <= ST_OK;
                end else begin
                  res_status <= ST_NOT_PENDING;
                end
                state <= S_F_SCAN;
              end
              ACT_PROCESS: begin
                state <= S_P_SCAN;
              end
              default: begin
                res_kind   <= EVT_NONE;
                res_slot   <= '0;
                res_status <= ST_OK;
                state      <= S_F_SCAN;
              end
            endcase
          end
        end

        S_A_SCAN: begin
          if (scan_last) begin
            state <= S_A_DEC;
          end
        end

        S_A_DEC: begin
          res_kind <= EVT_ADDED;
          if (flags.free_found) begin
            slot_valid[free_idx] <= 1'b1;
            order_counter <= order_counter + ORDER_W'(1);
            res_slot   <= free_wide[SLOT_ID_W-1:0];
            res_status <= ST_OK;
            res_wake   <= !flags.found || (item.expire_at < best_expire);
          end else begin
            res_slot   <= '0;
            res_status <= ST_FULL;
          end
          cnt   <= '0;
          state <= S_F_SCAN;
        end

        S_P_SCAN: begin
          if (scan_last) begin
            state <= S_P_NEXT;
          end
        end

        S_P_NEXT: begin
          cnt <= '0;
          if (flags.found) begin
            taken[best_idx] <= 1'b1;
            n     <= n + CNT_W'(1);
            state <= S_P_SCAN;
          end else if (n == '0) begin
            res_kind   <= EVT_NONE;
            res_slot   <= '0;
            res_status <= ST_OK;
            state      <= S_F_SCAN;
          end else begin
            k     <= '0;
            state <= S_R_LA;
          end
        end

        S_R_LA: begin
          state <= S_R_LB;
        end

        S_R_LB: begin
          state <= S_R_W;
        end

        S_R_W: begin
          // Rearm periodic timers in pick order, free one-shots
          if (mem_q.period != '0) begin
            order_counter <= order_counter + ORDER_W'(1);
          end else begin
            slot_valid[list_q] <= 1'b0;
          end
          if (k_last) begin
            k     <= '0;
            cnt   <= '0;
            state <= S_F_SCAN;
          end else begin
            k     <= k + CNT_W'(1);
            state <= S_R_LA;
          end
        end

        S_F_SCAN: begin
          if (scan_last) begin
            state <= S_F_DONE;
          end
        end

        S_F_DONE: begin
          if (item.action == ACT_PROCESS && n != '0) begin
            state <= S_E_RD;
          end else if (out_free) begin
            evt_valid <= 1'b1;
            evt <= '{event_kind: res_kind, slot_id: res_slot, status: res_status,
                     wakeup: res_wake, next_valid: flags.found,
                     next_time: next_time, last: 1'b1};
            state <= S_IDLE;
          end
        end

        S_E_RD: begin
          state <= S_E_LD;
        end

        S_E_LD: begin
          if (out_free) begin
            evt_valid <= 1'b1;
            evt <= '{event_kind: EVT_EXPIRED, slot_id: list_wide[SLOT_ID_W-1:0],
                     status: ST_OK, wakeup: 1'b0, next_valid: flags.found,
                     next_time: next_time, last: k_last};
            if (k_last) begin
              state <= S_IDLE;
            end else begin
              k     <= k + CNT_W'(1);
              state <= S_E_RD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A timer is never picked twice in one process command
  a_pick_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_P_NEXT && flags.found) |-> !taken[best_idx])
    else $error("expiry pick repeats a slot");

  // The expiry list never holds more entries than there are slots
  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(NUM_TIMERS))
    else $error("expiry list overflow");

  // Loading the final expiry word ends the command
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_E_LD && out_free && k_last) |=> (state == S_IDLE && evt_valid && evt.last))
    else $error("final expiry word not closing the command");

  // An empty queue always reports the all-ones time
  a_empty_time: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt.next_valid) |-> (evt.next_time == '1))
    else $error("empty queue with a pending time");

  // Wakeup only ever accompanies a successful add
  a_wake_add: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt.wakeup) |-> (evt.event_kind == EVT_ADDED && evt.status == ST_OK))
    else $error("wakeup on a word that is not an add");

endmodule

`default_nettype wire
